// ===== src/cbt_pkg.sv =====
// Shared types, codes and constants of the configurable byte tokenizer
`timescale 1ns / 1ps

package cbt_pkg;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 11;
  localparam int MAP_W     = 64;
  localparam int NUM_MAPS  = 8;
  localparam int CFG_IDX_W = 4;

  // Longest word kept; the limit is capped at the length field's maximum
  localparam int MAX_WORD_LEN = 2046;
  localparam int COUNT_MAX    = (1 << COUNT_W) - 1;
  localparam logic [COUNT_W-1:0] WORD_LEN_LIMIT =
    (MAX_WORD_LEN > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(MAX_WORD_LEN);

  localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

  // Result queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Input item kinds
  typedef enum logic {
    ITEM_DATA = 1'b0,
    ITEM_EOS  = 1'b1
  } item_kind_t;

  // Byte classes
  typedef enum logic [1:0] {
    CLASS_SEPARATOR  = 2'd0,
    CLASS_WORD       = 2'd1,
    CLASS_WHITESPACE = 2'd2,
    CLASS_COMMENT    = 2'd3
  } byte_class_t;

  // Token kinds
  typedef enum logic [1:0] {
    TK_WORD_BYTE = 2'd0,
    TK_WORD_END  = 2'd1,
    TK_SEPARATOR = 2'd2,
    TK_EOS       = 2'd3
  } token_kind_t;

  // One result item
  typedef struct packed {
    token_kind_t        kind;
    logic [BYTE_W-1:0]  tbyte;
    logic [COUNT_W-1:0] count;
    logic               trunc;
    logic               last;
  } tok_t;

  // Results produced by one item, handed to the result queue
  typedef struct packed {
    logic [1:0] n;
    tok_t       r0;
    tok_t       r1;
  } push_t;

  // Result queue status
  typedef struct packed {
    logic                  space_ok;
    logic [FIFO_CNT_W-1:0] level;
  } fifo_stat_t;

endpackage

// ===== src/cbt_in_if.sv =====
// Input request channel: data byte or end-of-stream mark
`timescale 1ns / 1ps

interface cbt_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// ===== src/cbt_tok_if.sv =====
// Output request channel: one token per request
`timescale 1ns / 1ps

interface cbt_tok_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [7:0]  token_byte;
  logic [10:0] word_count;
  logic        word_truncated;
  logic        last_of_run;

  modport source (output valid, output token_kind, output token_byte,
                  output word_count, output word_truncated, output last_of_run,
                  input ready);
  modport sink   (input valid, input token_kind, input token_byte,
                  input word_count, input word_truncated, input last_of_run,
                  output ready);
endinterface

// ===== src/configurable_byte_tokenizer.sv =====
// Top level of the configurable byte tokenizer
`timescale 1ns / 1ps

// Byte tokenizer: every data byte is classified through a 256-entry map of two-bit
// classes (separator, word, whitespace, comment) written as eight 64-bit registers,
// all separators after reset. One request is accepted per clock unless input stalls;
// a request goes through an input register and a class lookup, and its tokens are
// registered into a four-entry result queue. The queue delivers one token per cycle
// while the output is ready, so a request that ends a word and also yields a
// separator or end-of-stream token puts two tokens on the output, and input stalls
// when a request is held and the queue has fewer than two free entries. Words longer
// than 2046 bytes are cut and flagged at word end. Write the map only while idle.
module configurable_byte_tokenizer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cbt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbt_pkg::MAP_W-1:0]     cfg_data,
  cbt_in_if.sink                        in_stream,
  cbt_tok_if.source                     tok_stream
);
  import cbt_pkg::*;

  logic [BYTE_W-1:0] lookup_byte;
  byte_class_t       lookup_class;
  push_t             push;
  fifo_stat_t        fifo_stat;

  cbt_class_map u_class_map (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .lookup_byte  (lookup_byte),
    .lookup_class (lookup_class)
  );

  cbt_core u_core (
    .clk          (clk),
    .rst          (rst),
    .in_stream    (in_stream),
    .space_ok     (fifo_stat.space_ok),
    .lookup_byte  (lookup_byte),
    .lookup_class (lookup_class),
    .push         (push)
  );

  cbt_tok_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .tok  (tok_stream),
    .stat (fifo_stat)
  );

`ifndef SYNTHESIS
  // Queue never overfills
  assert property (@(posedge clk) disable iff (rst)
    fifo_stat.level <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  // Pushes only happen with room for two tokens
  assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> fifo_stat.space_ok)
    else $error("push without room");

  // A single-token push carries the end-of-run mark
  assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd1) |-> push.r0.last)
    else $error("single token not marked last");

  // A two-token push marks only the second token
  assert property (@(posedge clk) disable iff (rst)
    (push.n == 2'd2) |-> (push.r1.last && !push.r0.last &&
                          push.r0.kind == TK_WORD_END))
    else $error("two-token push malformed");

  // An accepted request is held next cycle, so input opens only when it can leave
  assert property (@(posedge clk) disable iff (rst)
    (in_stream.valid && in_stream.ready) |=> (in_stream.ready == fifo_stat.space_ok))
    else $error("request overwritten");
`endif

endmodule

// ===== src/cbt_class_map.sv =====
// Class map registers and byte class lookup
`timescale 1ns / 1ps

module cbt_class_map (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cbt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cbt_pkg::MAP_W-1:0]     cfg_data,
  input  logic [cbt_pkg::BYTE_W-1:0]    lookup_byte,
  output cbt_pkg::byte_class_t          lookup_class
);
  import cbt_pkg::*;

  localparam int SEL_W = $clog2(NUM_MAPS);

  logic [MAP_W-1:0] class_map [NUM_MAPS];
  logic [MAP_W-1:0] map_word;

  // Write a map word; indexes past the last word are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_MAPS; i++) begin
        class_map[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_MAPS))) begin
      class_map[cfg_index[SEL_W-1:0]] <= cfg_data;
    end
  end

  // Pick the word, then the two-bit field of the byte
  always_comb begin
    map_word     = class_map[lookup_byte[BYTE_W-1 -: SEL_W]];
    lookup_class = byte_class_t'(map_word[{lookup_byte[BYTE_W-SEL_W-1:0], 1'b0} +: 2]);
  end

endmodule

// ===== src/cbt_core.sv =====
// Input register, tokenizer state and result generation
`timescale 1ns / 1ps

module cbt_core (
  input  logic                       clk,
  input  logic                       rst,
  cbt_in_if.sink                     in_stream,
  input  logic                       space_ok,
  output logic [cbt_pkg::BYTE_W-1:0] lookup_byte,
  input  cbt_pkg::byte_class_t       lookup_class,
  output cbt_pkg::push_t             push
);
  import cbt_pkg::*;

  // Held request
  logic               held_valid;
  logic               held_kind;
  logic [BYTE_W-1:0]  held_byte;

  // Tokenizer state
  logic               inside_word,   inside_word_next;
  logic               inside_comment, inside_comment_next;
  logic [COUNT_W-1:0] stored_length, stored_length_next;
  logic               overflowed,    overflowed_next;

  logic               accept;
  logic               advance;
  logic [COUNT_W-1:0] len_eff;
  tok_t               word_end_tok;
  tok_t               r0, r1;
  logic [1:0]         n;

  assign accept          = in_stream.valid && in_stream.ready;
  assign advance         = held_valid && space_ok;
  assign in_stream.ready = !held_valid || space_ok;
  assign lookup_byte     = held_byte;

  // Take a new request whenever the held one leaves or the register is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_kind <= in_stream.kind;
      held_byte <= in_stream.data_byte;
    end
  end

  // Hold state until the held request is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_word    <= 1'b0;
      inside_comment <= 1'b0;
      stored_length  <= '0;
      overflowed     <= 1'b0;
    end else if (advance) begin
      inside_word    <= inside_word_next;
      inside_comment <= inside_comment_next;
      stored_length  <= stored_length_next;
      overflowed     <= overflowed_next;
    end
  end

  // Build up to two results and the next state
  always_comb begin
    inside_word_next    = inside_word;
    inside_comment_next = inside_comment;
    stored_length_next  = stored_length;
    overflowed_next     = overflowed;
    len_eff             = stored_length;
    n                   = 2'd0;
    r0                  = '0;
    r1                  = '0;

    word_end_tok        = '0;
    word_end_tok.kind   = TK_WORD_END;
    word_end_tok.count  = stored_length;
    word_end_tok.trunc  = overflowed;

    if (held_kind == ITEM_EOS) begin
      // Close an open word, report end, clear everything
      if (inside_word) begin
        r0      = word_end_tok;
        r1.kind = TK_EOS;
        n       = 2'd2;
      end else begin
        r0.kind = TK_EOS;
        n       = 2'd1;
      end
      inside_word_next    = 1'b0;
      inside_comment_next = 1'b0;
      stored_length_next  = '0;
      overflowed_next     = 1'b0;
    end else if (inside_comment && (held_byte != NEWLINE_BYTE)) begin
      // Drop bytes inside a comment
      n = 2'd0;
    end else begin
      inside_comment_next = 1'b0;
      if (lookup_class == CLASS_WORD) begin
        // Start a word if needed, pass the byte while under the limit
        if (!inside_word) begin
          len_eff         = '0;
          overflowed_next = 1'b0;
        end
        inside_word_next = 1'b1;
        if (len_eff < WORD_LEN_LIMIT) begin
          r0.kind            = TK_WORD_BYTE;
          r0.tbyte           = held_byte;
          r0.count           = len_eff;
          n                  = 2'd1;
          stored_length_next = len_eff + COUNT_W'(1);
        end else begin
          stored_length_next = len_eff;
          overflowed_next    = 1'b1;
        end
      end else begin
        // End an open word, then report a separator or enter a comment
        inside_word_next = 1'b0;
        if (inside_word) begin
          r0 = word_end_tok;
          if (lookup_class == CLASS_SEPARATOR) begin
            r1.kind  = TK_SEPARATOR;
            r1.tbyte = held_byte;
            n        = 2'd2;
          end else begin
            n = 2'd1;
          end
        end else if (lookup_class == CLASS_SEPARATOR) begin
          r0.kind  = TK_SEPARATOR;
          r0.tbyte = held_byte;
          n        = 2'd1;
        end
        if (lookup_class == CLASS_COMMENT) begin
          inside_comment_next = 1'b1;
        end
      end
    end

    // Mark the final result of this request
    case (n)
      2'd1:    r0.last = 1'b1;
      2'd2:    r1.last = 1'b1;
      default: ;
    endcase

    push.n  = advance ? n : 2'd0;
    push.r0 = r0;
    push.r1 = r1;
  end

endmodule

// ===== src/cbt_tok_fifo.sv =====
// Result queue: takes up to two tokens a cycle, delivers one while the output is ready
`timescale 1ns / 1ps

module cbt_tok_fifo (
  input  logic                clk,
  input  logic                rst,
  input  cbt_pkg::push_t      push,
  cbt_tok_if.source           tok,
  output cbt_pkg::fifo_stat_t stat
);
  import cbt_pkg::*;

  tok_t                  entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] level;
  logic                  pop;
  tok_t                  head;

  assign pop  = tok.valid && tok.ready;
  assign head = entries[rd_ptr];

  // Store the pushed tokens in order
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entries[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      entries[wr_ptr + FIFO_PTR_W'(1)] <= push.r1;
    end
  end

  // Advance pointers and the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      level <= level + FIFO_CNT_W'(push.n) - FIFO_CNT_W'(pop);
    end
  end

  assign tok.valid          = (level != '0);
  assign tok.token_kind     = head.kind;
  assign tok.token_byte     = head.tbyte;
  assign tok.word_count     = head.count;
  assign tok.word_truncated = head.trunc;
  assign tok.last_of_run    = head.last;

  assign stat.space_ok = (level <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign stat.level    = level;

endmodule
